[sv/threshold_and_box_downsample_defines.svh]
// Assertion macros shared by the threshold and box downsample RTL.
`ifndef THRESHOLD_AND_BOX_DOWNSAMPLE_DEFINES_SVH
`define THRESHOLD_AND_BOX_DOWNSAMPLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TBDS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbds check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define TBDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbds check failed");

`endif

[sv/tbds_pkg.sv]
// Package: widths, register indexes and defaults for the threshold and box downsample.
package tbds_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = PIX_W + 1;
  localparam int DIM_CFG_W  = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_THR_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_ON    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd3;

  // Register reset values
  localparam logic [PIX_W-1:0] RST_THR_LEVEL   = 8'd0;
  localparam logic             RST_THR_ON      = 1'b1;
  localparam int               RST_LINE_WIDTH  = 640;
  localparam int               RST_FRAME_HEIGHT = 480;

endpackage

[sv/tbds_ifs.sv]
// Stream and configuration channel interfaces for the threshold and box downsample.
interface tbds_pix_in_if;
  logic                       valid;
  logic                       ready;
  logic [tbds_pkg::PIX_W-1:0] pixel;
  logic                       frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface tbds_pix_out_if;
  logic                       valid;
  logic                       ready;
  logic [tbds_pkg::PIX_W-1:0] out_pixel;
  logic                       frame_end;

  modport source (output valid, output out_pixel, output frame_end, input ready);
  modport sink   (input valid, input out_pixel, input frame_end, output ready);
endinterface

interface tbds_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tbds_pkg::CFG_IDX_W-1:0]  index;
  logic [tbds_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/tbds_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
module tbds_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/threshold_and_box_downsample.sv]
// Threshold and 2x2 box downsample top level.
// Throughput: one pixel per cycle while the output queue is not full, with no gaps at row or frame ends.
// A 2x2 block's result enters the output queue on the transfer of its bottom-right pixel.
// Line store: a MAX_WIDTH/2 x 9 RAM, read when the left pixel of an odd-row pair arrives.
// A two-entry output queue lets input continue while a result waits.
// Reset clears counters, queue and registers to defaults; the line store is not cleared.
`include "threshold_and_box_downsample_defines.svh"

module threshold_and_box_downsample #(
  parameter int MAX_WIDTH  = tbds_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tbds_pkg::DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  tbds_pix_in_if.sink        pix_in,
  tbds_pix_out_if.source     pix_out,
  tbds_cfg_if.sink           cfg
);

  localparam int PW    = tbds_pkg::PIX_W;
  localparam int SW    = tbds_pkg::SUM_W;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WD    = $clog2(MAX_WIDTH + 1);
  localparam int HD    = $clog2(MAX_HEIGHT + 1);
  localparam int W_RST = (tbds_pkg::RST_LINE_WIDTH > MAX_WIDTH) ?
                         MAX_WIDTH : tbds_pkg::RST_LINE_WIDTH;
  localparam int H_RST = (tbds_pkg::RST_FRAME_HEIGHT > MAX_HEIGHT) ?
                         MAX_HEIGHT : tbds_pkg::RST_FRAME_HEIGHT;

  // Configuration registers; dimensions are kept already clamped
  logic [PW-1:0] thr_level;
  logic          thr_on;
  logic [WD-1:0] w_eff;
  logic [HD-1:0] h_eff;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_level <= tbds_pkg::RST_THR_LEVEL;
      thr_on    <= tbds_pkg::RST_THR_ON;
      w_eff     <= WD'(W_RST);
      h_eff     <= HD'(H_RST);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        tbds_pkg::CFG_THR_LEVEL: thr_level <= cfg.data[PW-1:0];
        tbds_pkg::CFG_THR_ON:    thr_on    <= cfg.data[0];
        tbds_pkg::CFG_WIDTH: begin
          if (cfg.data < 12'd2) w_eff <= WD'(2);
          else if (32'(cfg.data) > 32'(MAX_WIDTH)) w_eff <= WD'(MAX_WIDTH);
          else w_eff <= WD'(cfg.data);
        end
        tbds_pkg::CFG_HEIGHT: begin
          if (cfg.data < 12'd2) h_eff <= HD'(2);
          else if (32'(cfg.data) > 32'(MAX_HEIGHT)) h_eff <= HD'(MAX_HEIGHT);
          else h_eff <= HD'(cfg.data);
        end
      endcase
    end
  end

  // Scan position and held left pixel
  logic [COL_W-1:0] col, col_cur, col_next;
  logic [ROW_W-1:0] row, row_cur, row_next;
  logic [PW-1:0]    held_pixel;

  logic             in_xfer;
  logic [PW-1:0]    p_thr;
  logic [WD-1:0]    wlim, col_inc;
  logic [HD-1:0]    hlim, row_inc;
  logic             in_range, col_odd, row_odd;
  logic [SW-1:0]    pair_sum;
  logic [SW:0]      block_sum;
  logic [SW-1:0]    line_rdata;
  logic             line_we, line_re;
  logic [AW-1:0]    slot;
  logic             push, blk_end;

  assign in_xfer = pix_in.valid && pix_in.ready;

  // Frame start clears the position before the pixel is used
  assign col_cur = pix_in.frame_start ? '0 : col;
  assign row_cur = pix_in.frame_start ? '0 : row;

  assign p_thr = (thr_on && (pix_in.pixel < thr_level)) ? '0 : pix_in.pixel;

  // Odd last column and row are dropped
  assign wlim     = {w_eff[WD-1:1], 1'b0};
  assign hlim     = {h_eff[HD-1:1], 1'b0};
  assign in_range = (WD'(col_cur) < wlim) && (HD'(row_cur) < hlim);
  assign col_odd  = col_cur[0];
  assign row_odd  = row_cur[0];
  assign slot     = AW'(col_cur >> 1);

  assign pair_sum  = SW'(held_pixel) + SW'(p_thr);
  assign block_sum = (SW+1)'(line_rdata) + (SW+1)'(pair_sum);

  // Even rows store pair sums; odd rows fetch them on the left pixel
  assign line_we = in_xfer && in_range && col_odd && !row_odd;
  assign line_re = in_xfer && in_range && !col_odd && row_odd;
  assign push    = in_xfer && in_range && col_odd && row_odd;
  assign blk_end = (WD'(col_cur) == wlim - WD'(1)) && (HD'(row_cur) == hlim - HD'(1));

  tbds_ram #(
    .WIDTH (SW),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (slot),
    .wdata (pair_sum),
    .re    (line_re),
    .raddr (slot),
    .rdata (line_rdata)
  );

  // Raster counters wrap at the effective size
  assign col_inc = WD'(col_cur) + WD'(1);
  assign row_inc = HD'(row_cur) + HD'(1);

  always_comb begin
    col_next = col_cur + COL_W'(1);
    row_next = row_cur;
    if (col_inc >= w_eff) begin
      col_next = '0;
      row_next = (row_inc >= h_eff) ? '0 : row_cur + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      held_pixel <= '0;
    end else if (in_xfer) begin
      col <= col_next;
      row <= row_next;
      if (in_range && !col_odd) begin
        held_pixel <= p_thr;
      end
    end
  end

  // Two-entry output queue: head register plus skid register
  logic          out_valid, skid_valid;
  logic [PW-1:0] out_pix, skid_pix;
  logic          out_end, skid_end;
  logic          pop;
  logic [PW-1:0] new_pix;

  assign new_pix      = block_sum[SW:2];
  assign pop          = out_valid && pix_out.ready;
  assign pix_in.ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      if (skid_valid) begin
        out_pix  <= skid_pix;
        out_end  <= skid_end;
        skid_pix <= new_pix;
        skid_end <= blk_end;
      end else begin
        out_pix <= new_pix;
        out_end <= blk_end;
      end
    end else if (push) begin
      skid_pix <= new_pix;
      skid_end <= blk_end;
    end
  end

  assign pix_out.valid     = out_valid;
  assign pix_out.out_pixel = out_pix;
  assign pix_out.frame_end = out_end;

  // Checks
  `TBDS_ASSERT_NOW(a_skid_needs_head, skid_valid, out_valid)
  `TBDS_ASSERT_NEXT(a_push_shows_result, push, out_valid)
  `TBDS_ASSERT_NOW(a_no_read_write_overlap, line_we || line_re, !(line_we && line_re))
  `TBDS_ASSERT_NEXT(a_held_queue_keeps, out_valid && !pix_out.ready && !push && !skid_valid,
                    out_valid && !skid_valid)

endmodule
